@@ hdl/sttk_pkg.sv @@
// Shared types, codes and the byte classifier of the source text tokenizer.
package sttk_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int OFFSET_MAX_BITS = 32;
    localparam int LEN_OUT_BITS    = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int PTR_BITS        = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS        = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [4:0] K_EOF    = 5'd0;
    localparam logic [4:0] K_ERR    = 5'd1;
    localparam logic [4:0] K_NAME   = 5'd2;
    localparam logic [4:0] K_INT    = 5'd3;
    localparam logic [4:0] K_FLOAT  = 5'd4;
    localparam logic [4:0] K_STR    = 5'd5;
    localparam logic [4:0] K_SYM    = 5'd6;
    localparam logic [4:0] K_DIR    = 5'd7;
    localparam logic [4:0] K_OP     = 5'd8;
    localparam logic [4:0] K_HASHBR = 5'd9;
    localparam logic [4:0] K_ASSIGN = 5'd10;
    localparam logic [4:0] K_COLON  = 5'd11;
    localparam logic [4:0] K_DOT    = 5'd12;
    localparam logic [4:0] K_COMMA  = 5'd13;
    localparam logic [4:0] K_BAR    = 5'd14;
    localparam logic [4:0] K_LPAR   = 5'd15;
    localparam logic [4:0] K_RPAR   = 5'd16;
    localparam logic [4:0] K_LBRK   = 5'd17;
    localparam logic [4:0] K_RBRK   = 5'd18;
    localparam logic [4:0] K_LBRC   = 5'd19;
    localparam logic [4:0] K_RBRC   = 5'd20;

    // error codes
    localparam logic [2:0] E_NONE        = 3'd0;
    localparam logic [2:0] E_HASH        = 3'd1;
    localparam logic [2:0] E_DOLLAR      = 3'd2;
    localparam logic [2:0] E_UNCLOSED    = 3'd3;
    localparam logic [2:0] E_ESCAPE      = 3'd4;
    localparam logic [2:0] E_QUOTE       = 3'd5;
    localparam logic [2:0] E_AT          = 3'd6;
    localparam logic [2:0] E_MEANINGLESS = 3'd7;

    typedef struct packed {
        logic       alpha;
        logic       digit;
        logic       hex;
        logic       op;
        logic       blank;
        logic       punct;
        logic [4:0] punct_kind;
    } char_class_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  code;
        char_class_t cls;
    } byte_req_t;

    typedef struct packed {
        logic [4:0]                 kind;
        logic [2:0]                 err;
        logic [OFFSET_MAX_BITS-1:0] off;
        logic [LEN_OUT_BITS-1:0]    len;
        logic                       last;
    } token_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r.digit = (c >= "0") && (c <= "9");
        r.alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
        r.hex   = r.digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
        r.op    = (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "<") ||
                  (c == ">") || (c == "=") || (c == "!") || (c == "&") || (c == "^") ||
                  (c == "%") || (c == "~") || (c == "?") || (c == "\\");
        r.blank = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
        r.punct = 1'b1;
        unique case (c)
            ".":     r.punct_kind = K_DOT;
            ",":     r.punct_kind = K_COMMA;
            "|":     r.punct_kind = K_BAR;
            "(":     r.punct_kind = K_LPAR;
            ")":     r.punct_kind = K_RPAR;
            "[":     r.punct_kind = K_LBRK;
            "]":     r.punct_kind = K_RBRK;
            "{":     r.punct_kind = K_LBRC;
            "}":     r.punct_kind = K_RBRC;
            default: begin
                r.punct      = 1'b0;
                r.punct_kind = K_ERR;
            end
        endcase
        return r;
    endfunction

endpackage

@@ hdl/sttk_front.sv @@
// Front end: accepts source bytes, classifies them and queues them for the lexer.
module sttk_front
    import sttk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output byte_req_t  head,
    input  logic       pop
);

    byte_req_t              q_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    wr_reg, rd_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   push;

    assign s_ready = (cnt_reg != CNT_BITS'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;

    // present the oldest byte
    always_comb begin
        head       = q_reg[rd_reg];
        head.valid = (cnt_reg != '0);
    end

    // store classified bytes
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg].valid <= 1'b1;
            q_reg[wr_reg].code  <= s_char_code;
            q_reg[wr_reg].cls   <= classify(s_char_code);
        end
    end

    // advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/sttk_lexer.sv @@
// Back end: scanner state machine that lexes bytes one at a time into token requests.
module sttk_lexer
    import sttk_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  byte_req_t head,
    output logic      pop,
    input  logic      outq_full,
    output logic      push,
    output token_t    push_data
);

    localparam int OB = OFFSET_BITS;
    localparam int LB = LENGTH_BITS;

    localparam logic [4:0] M_IDLE = 5'd0,  M_COMMENT = 5'd1,  M_NAME = 5'd2,  M_HASH = 5'd3,
                           M_HASHNEG = 5'd4, M_DEC = 5'd5,    M_DOLLAR = 5'd6, M_HEX = 5'd7,
                           M_PCT = 5'd8,   M_BIN = 5'd9,      M_FINT = 5'd10, M_FDOT = 5'd11,
                           M_FFRAC = 5'd12, M_FE = 5'd13,     M_FESIGN = 5'd14, M_FEXP = 5'd15,
                           M_STR = 5'd16,  M_QUOTE = 5'd17,   M_SYMB = 5'd18, M_AT = 5'd19,
                           M_DIRB = 5'd20, M_COLON = 5'd21,   M_BAR = 5'd22,  M_OPR = 5'd23;

    localparam logic [1:0] A_DONE = 2'd0, A_AGAIN = 2'd1, A_RELEX = 2'd2;

    logic [4:0]    mode_reg, mode_next;
    logic [OB-1:0] tbeg_reg, tbeg_next;
    logic [OB-1:0] pos_reg, pos_next;
    logic [LB-1:0] run_reg, run_next;
    logic [7:0]    held_reg [2];
    logic [7:0]    held_next [2];
    logic [1:0]    hcnt_reg, hcnt_next;
    logic          esc_reg, esc_next;
    logic [7:0]    replay_reg [2];
    logic [7:0]    replay_next [2];
    logic [1:0]    rcnt_reg, rcnt_next;

    logic          pv_reg, plast_reg;
    token_t        pend_reg;

    logic [7:0]    c;
    char_class_t   cl;
    logic          have, go, step_end;
    logic [1:0]    act;
    logic          emit, eof_hit;
    logic [4:0]    e_kind;
    logic [2:0]    e_err;
    logic [OB-1:0] e_off;
    logic [LB-1:0] e_run;
    logic [LB+15:0] e_ext;
    token_t        new_tok;
    logic [LB+1:0] sum1, sumh;
    logic [LB-1:0] run_g1, run_gh;

    // pick the byte to feed: replayed lookahead first
    always_comb begin
        c    = (rcnt_reg != 2'd0) ? replay_reg[0] : head.code;
        cl   = (rcnt_reg != 2'd0) ? classify(replay_reg[0]) : head.cls;
        have = (rcnt_reg != 2'd0) || head.valid;
        go   = have && (!pv_reg || !outq_full);
    end

    // saturating length growth
    always_comb begin
        sum1   = {2'b00, run_reg} + (LB+2)'(1);
        sumh   = {2'b00, run_reg} + (LB+2)'(hcnt_reg) + (LB+2)'(1);
        run_g1 = (sum1[LB+1:LB] != 2'b00) ? '1 : sum1[LB-1:0];
        run_gh = (sumh[LB+1:LB] != 2'b00) ? '1 : sumh[LB-1:0];
    end

    // scan one byte
    always_comb begin
        mode_next      = mode_reg;
        tbeg_next      = tbeg_reg;
        run_next       = run_reg;
        held_next      = held_reg;
        hcnt_next      = hcnt_reg;
        esc_next       = esc_reg;
        replay_next    = replay_reg;
        rcnt_next      = rcnt_reg;
        pos_next       = pos_reg;
        act            = A_DONE;
        emit           = 1'b0;
        eof_hit        = 1'b0;
        e_kind         = K_EOF;
        e_err          = E_NONE;
        e_off          = tbeg_reg;
        e_run          = run_reg;

        unique case (mode_reg)
            M_IDLE: begin
                e_off = pos_reg;
                e_run = LB'(1);
                priority if (c == 8'h00) begin
                    emit      = 1'b1;
                    e_run     = '0;
                    eof_hit   = 1'b1;
                    tbeg_next = '0;
                    run_next  = '0;
                    hcnt_next = 2'd0;
                    esc_next  = 1'b0;
                end else if (cl.blank) begin
                    mode_next = M_IDLE;
                end else if (c == ";") begin
                    mode_next = M_COMMENT;
                end else if (cl.alpha || cl.digit || c == "#" || c == "$" || c == "%" ||
                             c == "\"" || c == "'" || c == "@" || c == ":" || c == "|" ||
                             cl.op) begin
                    tbeg_next = pos_reg;
                    run_next  = LB'(1);
                    priority if (cl.alpha)  mode_next = M_NAME;
                    else if (c == "#")      mode_next = M_HASH;
                    else if (c == "$")      mode_next = M_DOLLAR;
                    else if (c == "%")      mode_next = M_PCT;
                    else if (cl.digit)      mode_next = M_FINT;
                    else if (c == "\"") begin
                        mode_next = M_STR;
                        esc_next  = 1'b0;
                    end
                    else if (c == "'")      mode_next = M_QUOTE;
                    else if (c == "@")      mode_next = M_AT;
                    else if (c == ":")      mode_next = M_COLON;
                    else if (c == "|")      mode_next = M_BAR;
                    else                    mode_next = M_OPR;
                end else if (cl.punct) begin
                    emit   = 1'b1;
                    e_kind = cl.punct_kind;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_ERR;
                    e_err  = E_MEANINGLESS;
                end
            end
            M_COMMENT: begin
                if (c == 8'h00) begin
                    mode_next = M_IDLE;
                    act       = A_AGAIN;
                end else if (c == 8'h0A) begin
                    mode_next = M_IDLE;
                end
            end
            M_NAME, M_SYMB, M_DIRB: begin
                if (cl.alpha || cl.digit) begin
                    run_next = run_g1;
                end else begin
                    emit   = 1'b1;
                    e_kind = (mode_reg == M_NAME) ? K_NAME :
                             (mode_reg == M_SYMB) ? K_SYM : K_DIR;
                    act    = A_AGAIN;
                end
            end
            M_HASH, M_HASHNEG: begin
                if (mode_reg == M_HASH && c == "[") begin
                    emit   = 1'b1;
                    e_kind = K_HASHBR;
                    e_run  = run_g1;
                end else if (mode_reg == M_HASH && c == "-") begin
                    run_next  = run_g1;
                    mode_next = M_HASHNEG;
                end else if (cl.digit) begin
                    run_next  = run_g1;
                    mode_next = M_DEC;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_ERR;
                    e_err  = E_HASH;
                    act    = A_AGAIN;
                end
            end
            M_DEC, M_HEX, M_BIN, M_FEXP: begin
                if ((mode_reg == M_DEC && cl.digit) || (mode_reg == M_HEX && cl.hex) ||
                    (mode_reg == M_BIN && (c == "0" || c == "1")) ||
                    (mode_reg == M_FEXP && cl.digit)) begin
                    run_next = run_g1;
                end else begin
                    emit   = 1'b1;
                    e_kind = (mode_reg == M_FEXP) ? K_FLOAT : K_INT;
                    act    = A_AGAIN;
                end
            end
            M_DOLLAR: begin
                if (cl.hex) begin
                    run_next  = run_g1;
                    mode_next = M_HEX;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_ERR;
                    e_err  = E_DOLLAR;
                    act    = A_AGAIN;
                end
            end
            M_PCT: begin
                if (c == "0" || c == "1") begin
                    run_next  = run_g1;
                    mode_next = M_BIN;
                end else begin
                    mode_next = M_OPR;
                    act       = A_AGAIN;
                end
            end
            M_FINT, M_FFRAC: begin
                if (cl.digit) begin
                    run_next = run_g1;
                end else if ((c == "." && mode_reg == M_FINT) || c == "e" || c == "E") begin
                    if (hcnt_reg != 2'd2) begin
                        held_next[hcnt_reg[0]] = c;
                        hcnt_next              = hcnt_reg + 2'd1;
                    end
                    mode_next = (c == ".") ? M_FDOT : M_FE;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_FLOAT;
                    act    = A_AGAIN;
                end
            end
            M_FDOT, M_FE, M_FESIGN: begin
                if (mode_reg == M_FE && (c == "+" || c == "-")) begin
                    if (hcnt_reg != 2'd2) begin
                        held_next[hcnt_reg[0]] = c;
                        hcnt_next              = hcnt_reg + 2'd1;
                    end
                    mode_next = M_FESIGN;
                end else if (cl.digit) begin
                    run_next  = run_gh;
                    hcnt_next = 2'd0;
                    mode_next = (mode_reg == M_FDOT) ? M_FFRAC : M_FEXP;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_FLOAT;
                    act    = A_RELEX;
                end
            end
            M_STR: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                    if (c == "\"" || c == "\\" || c == "n" || c == "t" || c == "r") begin
                        run_next  = run_gh;
                        hcnt_next = 2'd0;
                    end else begin
                        emit   = 1'b1;
                        e_kind = K_ERR;
                        e_err  = E_ESCAPE;
                        e_off  = pos_reg - OB'(hcnt_reg);
                        e_run  = '0;
                        act    = A_RELEX;
                    end
                end else if (c == "\"") begin
                    emit   = 1'b1;
                    e_kind = K_STR;
                    e_run  = run_g1;
                end else if (c == 8'h00) begin
                    emit   = 1'b1;
                    e_kind = K_ERR;
                    e_err  = E_UNCLOSED;
                    act    = A_AGAIN;
                end else if (c == "\\") begin
                    if (hcnt_reg != 2'd2) begin
                        held_next[hcnt_reg[0]] = c;
                        hcnt_next              = hcnt_reg + 2'd1;
                    end
                    esc_next = 1'b1;
                end else begin
                    run_next = run_g1;
                end
            end
            M_QUOTE, M_AT: begin
                if (cl.alpha) begin
                    run_next  = run_g1;
                    mode_next = (mode_reg == M_QUOTE) ? M_SYMB : M_DIRB;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_ERR;
                    e_err  = (mode_reg == M_QUOTE) ? E_QUOTE : E_AT;
                    act    = A_AGAIN;
                end
            end
            M_COLON: begin
                emit = 1'b1;
                if (c == "=") begin
                    e_kind = K_ASSIGN;
                    e_run  = run_g1;
                end else begin
                    e_kind = K_COLON;
                    act    = A_AGAIN;
                end
            end
            M_BAR: begin
                if (c == "|") begin
                    run_next  = run_g1;
                    mode_next = M_OPR;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_BAR;
                    act    = A_AGAIN;
                end
            end
            M_OPR: begin
                if (cl.op) begin
                    run_next = run_g1;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_OP;
                    act    = A_AGAIN;
                end
            end
            default: begin
                mode_next = M_IDLE;
                hcnt_next = 2'd0;
                esc_next  = 1'b0;
                act       = A_AGAIN;
            end
        endcase

        // a token that ends returns the scanner to idle
        if (emit && mode_reg != M_IDLE) begin
            mode_next = M_IDLE;
            run_next  = '0;
        end

        // advance past the byte, or rewind to lex the held bytes again
        if (act == A_DONE) begin
            pos_next = eof_hit ? '0 : pos_reg + 1'b1;
            if (rcnt_reg != 2'd0) begin
                replay_next[0] = replay_reg[1];
                rcnt_next      = rcnt_reg - 2'd1;
            end
        end else if (act == A_RELEX) begin
            replay_next = held_reg;
            rcnt_next   = hcnt_reg;
            pos_next    = pos_reg - OB'(hcnt_reg);
            mode_next   = M_IDLE;
            hcnt_next   = 2'd0;
            esc_next    = 1'b0;
        end
    end

    assign step_end = go && (act == A_DONE) && (rcnt_reg == 2'd0);
    assign pop      = step_end;

    // build the token request
    always_comb begin
        e_ext        = {16'b0, e_run};
        new_tok.kind = e_kind;
        new_tok.err  = e_err;
        new_tok.off  = OFFSET_MAX_BITS'(e_off);
        new_tok.len  = (e_ext[LB+15:16] != '0) ? '1 : e_ext[15:0];
        new_tok.last = 1'b0;
    end

    assign push = pv_reg && !outq_full && (plast_reg || (go && emit));

    always_comb begin
        push_data      = pend_reg;
        push_data.last = plast_reg;
    end

    // update scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            tbeg_reg <= '0;
            pos_reg  <= '0;
            run_reg  <= '0;
            hcnt_reg <= 2'd0;
            esc_reg  <= 1'b0;
            rcnt_reg <= 2'd0;
        end else if (go) begin
            mode_reg <= mode_next;
            tbeg_reg <= tbeg_next;
            pos_reg  <= pos_next;
            run_reg  <= run_next;
            hcnt_reg <= hcnt_next;
            esc_reg  <= esc_next;
            rcnt_reg <= rcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            held_reg   <= held_next;
            replay_reg <= replay_next;
        end
    end

    // hold the newest token until it is known whether it closes the run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
        end else if (go && emit) begin
            pv_reg    <= 1'b1;
            plast_reg <= step_end;
        end else if (push) begin
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
        end else if (step_end && pv_reg) begin
            plast_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && emit) begin
            pend_reg <= new_tok;
        end
    end

    // checks
    a_hcnt: assert property (@(posedge aclk) disable iff (!aresetn) hcnt_reg != 2'd3)
        else $error("held count out of range");
    a_rcnt: assert property (@(posedge aclk) disable iff (!aresetn) rcnt_reg != 2'd3)
        else $error("replay count out of range");
    a_relex: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && act == A_RELEX) |=> (rcnt_reg == $past(hcnt_reg) && mode_reg == M_IDLE))
        else $error("relex did not load held bytes");
    a_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (mode_reg == M_STR && hcnt_reg == 2'd1))
        else $error("escape open outside string");
    a_plast: assert property (@(posedge aclk) disable iff (!aresetn)
        plast_reg |-> pv_reg)
        else $error("run end flagged with no pending token");

endmodule

@@ hdl/sttk_outq.sv @@
// Output queue: buffers token requests toward the result channel.
module sttk_outq
    import sttk_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  token_t                 push_data,
    output logic                   full,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [4:0]             m_token_kind,
    output logic [2:0]             m_error_kind,
    output logic [OFFSET_BITS-1:0] m_token_offset,
    output logic [LEN_OUT_BITS-1:0] m_token_length,
    output logic                   m_last_of_run
);

    token_t              q_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, rd_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                pop;
    token_t              head;

    assign full    = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));
    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;
    assign head    = q_reg[rd_reg];

    assign m_token_kind   = head.kind;
    assign m_error_kind   = head.err;
    assign m_token_offset = head.off[OFFSET_BITS-1:0];
    assign m_token_length = head.len;
    assign m_last_of_run  = head.last;

    // store requests
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= push_data;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/source_text_tokenizer_core.sv @@
// Source text tokenizer top level: byte queue, scanner and token queue.
//
// Input channel s_*: one source byte per request, byte 0 ends the text.
// Output channel m_*: one token record per request (kind, error code,
// offset, saturated length, last_of_run on the final token of a byte).
// A four-entry byte queue feeds the scanner; the scanner runs one scan
// step per cycle while it has a byte and no pending token waits on a
// full token queue. A byte that ends a token without being part of it
// is scanned again once the token is emitted. A failed lookahead emits
// on the failing step, then replays the held bytes before that byte is
// scanned again. A token passes through the byte queue, the scan step,
// the run-end hold and then the four-entry token queue, in that order.
// The newest token waits in the hold until the next token or the end of
// its byte shows whether it closes the run.
// When the receiver stalls the token queue fills, the scanner stops and
// the byte queue fills, then s_ready drops; nothing is lost.
// Reset clears the queues and returns the scanner to idle at offset zero.
module source_text_tokenizer_core
    import sttk_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_char_code,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [4:0]              m_token_kind,
    output logic [2:0]              m_error_kind,
    output logic [OFFSET_BITS-1:0]  m_token_offset,
    output logic [LEN_OUT_BITS-1:0] m_token_length,
    output logic                    m_last_of_run
);

    byte_req_t head;
    logic      pop;
    logic      outq_full;
    logic      push;
    token_t    push_data;

    sttk_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .head        (head),
        .pop         (pop)
    );

    sttk_lexer #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .outq_full (outq_full),
        .push      (push),
        .push_data (push_data)
    );

    sttk_outq #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_outq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (push),
        .push_data      (push_data),
        .full           (outq_full),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_error_kind   (m_error_kind),
        .m_token_offset (m_token_offset),
        .m_token_length (m_token_length),
        .m_last_of_run  (m_last_of_run)
    );

endmodule
